// File: hdl/ostt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table package
// Shared field widths, operation and status codes, and the controller states.
// ----------------------------------------------------------------------------
package ostt_pkg;

	// Fixed widths of the channel fields.
	localparam int FIELD_TIME_W = 48;
	localparam int ID_W         = 32;
	localparam int OP_W         = 3;
	localparam int STATUS_W     = 2;

	// At most this many timers fire on one tick.
	localparam int MAX_RESULTS  = 16;
	localparam int CNT_W        = 5;

	// One millisecond in the fixed-point time format (10 fraction bits).
	localparam int ONE_MS       = 1024;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ARM_ONESHOT   = 3'd0;
	localparam logic [OP_W-1:0] OP_ARM_PERIODIC  = 3'd1;
	localparam logic [OP_W-1:0] OP_CLR_ONESHOT   = 3'd2;
	localparam logic [OP_W-1:0] OP_CLR_PERIODIC  = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK_ONESHOT  = 3'd4;
	localparam logic [OP_W-1:0] OP_TICK_PERIODIC = 3'd5;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NEG  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	// Timer kinds.
	localparam logic KIND_ONESHOT  = 1'b0;
	localparam logic KIND_PERIODIC = 1'b1;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_ARM,
		S_CLR,
		S_BUILD,
		S_MIN,
		S_EMIT,
		S_ADV_RD,
		S_ADV_LD,
		S_ADV_DIV,
		S_ADV_WR,
		S_FREE,
		S_RESP
	} state_t;

endpackage

// File: hdl/ostt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table request channel
// Valid/ready channel that carries one command to the timer table.
// ----------------------------------------------------------------------------
interface ostt_in_if import ostt_pkg::*; ();
	logic                           valid;
	logic                           ready;
	logic [OP_W-1:0]                opcode;
	logic signed [FIELD_TIME_W-1:0] delay_value;
	logic [ID_W-1:0]                timer_id;
	logic [FIELD_TIME_W-1:0]        now_time;

	modport source(output valid, opcode, delay_value, timer_id, now_time, input ready);
	modport sink(input valid, opcode, delay_value, timer_id, now_time, output ready);
endinterface

// File: hdl/ostt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table response channel
// Valid/ready channel that carries one result of the timer table.
// ----------------------------------------------------------------------------
interface ostt_out_if import ostt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     assigned_id;
	logic [ID_W-1:0]     fired_id;
	logic                fired_valid;
	logic                fired_kind;
	logic                last;

	modport source(output valid, status, assigned_id, fired_id, fired_valid, fired_kind, last,
		input ready);
	modport sink(input valid, status, assigned_id, fired_id, fired_valid, fired_kind, last,
		output ready);
endinterface

// File: hdl/ostt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ostt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: hdl/ostt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module ostt_div #(
	parameter int W = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  shf_q;
	logic [W-1:0]  dvs_q;
	logic [W-1:0]  rem_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	// Bring down the next dividend bit and try the subtraction.
	always_comb begin
		trial = {rem_q, shf_q[W-1]};
		diff  = trial - {1'b0, dvs_q};
	end

	// Control: count W steps, then flag completion for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			shf_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			shf_q <= shf_q << 1;
			rem_q <= (trial >= {1'b0, dvs_q}) ? diff[W-1:0] : trial[W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

// File: hdl/oneshot_and_periodic_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-shot and periodic timer table
// Keeps TIMER_SLOTS one-shot and TIMER_SLOTS periodic timers, arms, clears
// and ticks them, and reports fired timer ids in ascending id order.
// ----------------------------------------------------------------------------
// One command is handled at a time. Ids, due times and periods sit in
// synchronous RAMs; used and active flags are flip-flops. An arm writes the
// chosen free slot, and a clear scans all slots for the id. A tick first scans
// all slots for due timers, then for every fired timer scans the slots again
// for the lowest id. A fired periodic timer also passes through the remainder
// unit to advance its due time. Results wait in an output register, and output
// stalls hold the controller.
module oneshot_and_periodic_timer_table
	import ostt_pkg::*;
#(
	parameter int TIMER_SLOTS = 16,
	parameter int TIME_WIDTH  = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	ostt_in_if.sink      req,
	ostt_out_if.source   rsp
);
	localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int TW = TIME_WIDTH;
	localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};
	localparam logic [TW-1:0] ONE_MS_T = TW'(ONE_MS);
	localparam logic [SW:0]   SLOTS_C  = (SW + 1)'(TIMER_SLOTS);

	function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [TW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TW] ? TIME_MAX : s[TW-1:0];
	endfunction

	state_t state_q, state_d;

	// Command registers.
	logic                    kind_q;
	logic [FIELD_TIME_W-1:0] delay_q;
	logic [ID_W-1:0]         id_q;
	logic [TW-1:0]           now_q;
	logic [STATUS_W-1:0]     status_q;
	logic [ID_W-1:0]         assigned_q;
	logic [SW-1:0]           slot_q;

	// Timer flags and id counters.
	logic [TIMER_SLOTS-1:0] os_used_q, p_used_q, p_active_q, cand_q;
	logic [ID_W-1:0]        next_os_id_q, next_p_id_q;

	// Slot scan.
	logic [SW:0]   scan_q;
	logic          rd_v_s1;
	logic [SW-1:0] rd_idx_s1;
	logic          scan_state, scan_issue, scan_done;

	// Lowest-id search and advance.
	logic            best_v_q;
	logic [ID_W-1:0] best_id_q;
	logic [SW-1:0]   best_slot_q;
	logic [CNT_W-1:0] n_q;
	logic            last_q;
	logic [TW-1:0]   per_q;

	// Output register.
	logic                out_v_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ID_W-1:0]     out_aid_q, out_fid_q;
	logic                out_fv_q, out_fk_q, out_last_q;

	// Decoded request.
	logic                accept, in_kind, in_arm, in_neg, free_found;
	logic [SW-1:0]       free_slot;
	logic [TIMER_SLOTS-1:0] used_sel;

	// Memory ports.
	logic            ram_re;
	logic [SW-1:0]   ram_raddr, ram_waddr;
	logic            os_we, p_arm_we, p_due_we;
	logic [TW-1:0]   due_wdata, arm_due, adv_due, arm_per;
	logic [ID_W-1:0] os_ident_rd, p_ident_rd, ident_rd;
	logic [TW-1:0]   os_due_rd, p_due_rd, p_per_rd, due_rd;

	// Result and divider control.
	logic                out_free, emit_req, emit_last;
	logic [STATUS_W-1:0] e_status;
	logic [ID_W-1:0]     e_aid, e_fid;
	logic                e_fv, e_fk, e_last;
	logic [TIMER_SLOTS-1:0] cand_rest;
	logic            div_start, div_done;
	logic [TW-1:0]   div_rem;

	// Timer storage.
	ostt_ram #(.WIDTH(ID_W), .DEPTH(TIMER_SLOTS)) u_os_ident (
		.clk, .we(os_we), .waddr(ram_waddr), .wdata(next_os_id_q),
		.re(ram_re), .raddr(ram_raddr), .rdata(os_ident_rd));
	ostt_ram #(.WIDTH(TW), .DEPTH(TIMER_SLOTS)) u_os_due (
		.clk, .we(os_we), .waddr(ram_waddr), .wdata(due_wdata),
		.re(ram_re), .raddr(ram_raddr), .rdata(os_due_rd));
	ostt_ram #(.WIDTH(ID_W), .DEPTH(TIMER_SLOTS)) u_p_ident (
		.clk, .we(p_arm_we), .waddr(ram_waddr), .wdata(next_p_id_q),
		.re(ram_re), .raddr(ram_raddr), .rdata(p_ident_rd));
	ostt_ram #(.WIDTH(TW), .DEPTH(TIMER_SLOTS)) u_p_per (
		.clk, .we(p_arm_we), .waddr(ram_waddr), .wdata(arm_per),
		.re(ram_re), .raddr(ram_raddr), .rdata(p_per_rd));
	ostt_ram #(.WIDTH(TW), .DEPTH(TIMER_SLOTS)) u_p_due (
		.clk, .we(p_due_we), .waddr(ram_waddr), .wdata(due_wdata),
		.re(ram_re), .raddr(ram_raddr), .rdata(p_due_rd));

	// Remainder of the overdue time by the period.
	ostt_div #(.W(TW)) u_div (
		.clk, .arst_n, .start(div_start), .dividend(now_q - p_due_rd),
		.divisor(p_per_rd), .done(div_done), .rem(div_rem));

	assign ident_rd = kind_q ? p_ident_rd : os_ident_rd;
	assign due_rd   = kind_q ? p_due_rd : os_due_rd;

	// Request decode and lowest free slot of the addressed kind.
	always_comb begin
		in_kind = KIND_ONESHOT;
		in_arm  = 1'b0;
		case (req.opcode)
			OP_ARM_ONESHOT:   in_arm = 1'b1;
			OP_ARM_PERIODIC:  begin in_arm = 1'b1; in_kind = KIND_PERIODIC; end
			OP_CLR_PERIODIC:  in_kind = KIND_PERIODIC;
			OP_TICK_PERIODIC: in_kind = KIND_PERIODIC;
			default:          in_kind = KIND_ONESHOT;
		endcase
		in_neg     = req.delay_value[FIELD_TIME_W-1];
		used_sel   = in_kind ? p_used_q : os_used_q;
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!used_sel[i]) begin
				free_found = 1'b1;
				free_slot  = SW'(i);
			end
		end
	end

	assign accept = req.valid && req.ready;

	// Arm values: period clamp and saturating due times.
	always_comb begin
		logic [FIELD_TIME_W-1:0] p_wide;
		p_wide  = (delay_q < FIELD_TIME_W'(ONE_MS)) ? FIELD_TIME_W'(ONE_MS) : delay_q;
		arm_per = TW'(p_wide);
		if (arm_per < ONE_MS_T) begin
			arm_per = ONE_MS_T;
		end
		arm_due = sat_add(now_q, kind_q ? arm_per : TW'(delay_q));
		adv_due = sat_add(now_q - div_rem, per_q);
	end

	// Scan bookkeeping.
	assign scan_state = (state_q == S_CLR) || (state_q == S_BUILD) || (state_q == S_MIN);
	assign scan_issue = scan_state && (scan_q != SLOTS_C);
	assign scan_done  = scan_state && (scan_q == SLOTS_C) && !rd_v_s1;

	assign out_free  = !out_v_q || rsp.ready;
	assign cand_rest = cand_q & ~(TIMER_SLOTS'(1) << best_slot_q);
	assign emit_last = (n_q == CNT_W'(MAX_RESULTS - 1)) || (cand_rest == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_arm) begin
						state_d = (in_neg || !free_found) ? S_RESP : S_ARM;
					end else if (req.opcode == OP_CLR_ONESHOT ||
							req.opcode == OP_CLR_PERIODIC) begin
						state_d = S_CLR;
					end else if (req.opcode == OP_TICK_ONESHOT ||
							req.opcode == OP_TICK_PERIODIC) begin
						state_d = S_BUILD;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_ARM:    state_d = S_RESP;
			S_CLR:    if (scan_done) state_d = S_RESP;
			S_BUILD: begin
				if (scan_done) begin
					if (cand_q != '0) state_d = S_MIN;
					else state_d = kind_q ? S_FREE : S_RESP;
				end
			end
			S_MIN: begin
				if (scan_done) begin
					if (best_v_q) state_d = S_EMIT;
					else state_d = kind_q ? S_FREE : S_IDLE;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					if (kind_q) state_d = S_ADV_RD;
					else state_d = emit_last ? S_IDLE : S_MIN;
				end
			end
			S_ADV_RD:  state_d = S_ADV_LD;
			S_ADV_LD:  state_d = S_ADV_DIV;
			S_ADV_DIV: if (div_done) state_d = S_ADV_WR;
			S_ADV_WR:  state_d = last_q ? S_FREE : S_MIN;
			S_FREE:    state_d = (n_q == '0) ? S_RESP : S_IDLE;
			S_RESP:    if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// State outputs: memory ports, divider start and result payload.
	always_comb begin
		req.ready = (state_q == S_IDLE);
		ram_re    = scan_issue || (state_q == S_ADV_RD);
		ram_raddr = (state_q == S_ADV_RD) ? best_slot_q : scan_q[SW-1:0];
		ram_waddr = (state_q == S_ADV_WR) ? best_slot_q : slot_q;
		os_we     = (state_q == S_ARM) && !kind_q;
		p_arm_we  = (state_q == S_ARM) && kind_q;
		p_due_we  = p_arm_we || (state_q == S_ADV_WR);
		due_wdata = (state_q == S_ADV_WR) ? adv_due : arm_due;
		div_start = (state_q == S_ADV_LD);
		emit_req  = 1'b0;
		e_status  = ST_OK;
		e_aid     = '0;
		e_fid     = '0;
		e_fv      = 1'b0;
		e_fk      = KIND_ONESHOT;
		e_last    = 1'b1;
		case (state_q)
			S_RESP: begin
				emit_req = 1'b1;
				e_status = status_q;
				e_aid    = assigned_q;
			end
			S_EMIT: begin
				emit_req = 1'b1;
				e_fid    = best_id_q;
				e_fv     = 1'b1;
				e_fk     = kind_q;
				e_last   = emit_last;
			end
			default: emit_req = 1'b0;
		endcase
	end

	// Controller registers and timer flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			os_used_q    <= '0;
			p_used_q     <= '0;
			p_active_q   <= '0;
			cand_q       <= '0;
			next_os_id_q <= ID_W'(1);
			next_p_id_q  <= ID_W'(1);
			scan_q       <= '0;
			rd_v_s1      <= 1'b0;
			best_v_q     <= 1'b0;
			n_q          <= '0;
			last_q       <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			state_q <= state_d;

			// Slot scan counter and read pipeline.
			rd_v_s1 <= scan_issue;
			if (!scan_state || scan_done) scan_q <= '0;
			else if (scan_issue) scan_q <= scan_q + 1'b1;

			case (state_q)
				S_IDLE: begin
					cand_q   <= '0;
					best_v_q <= 1'b0;
					n_q      <= '0;
				end
				S_ARM: begin
					if (kind_q) begin
						p_used_q[slot_q]   <= 1'b1;
						p_active_q[slot_q] <= 1'b1;
						next_p_id_q        <= next_p_id_q + 1'b1;
					end else begin
						os_used_q[slot_q] <= 1'b1;
						next_os_id_q      <= next_os_id_q + 1'b1;
					end
				end
				S_CLR: begin
					if (rd_v_s1 && ident_rd == id_q) begin
						if (kind_q) begin
							if (p_used_q[rd_idx_s1]) p_active_q[rd_idx_s1] <= 1'b0;
						end else begin
							os_used_q[rd_idx_s1] <= 1'b0;
						end
					end
				end
				S_BUILD: begin
					if (rd_v_s1) begin
						cand_q[rd_idx_s1] <= (kind_q ?
							(p_used_q[rd_idx_s1] && p_active_q[rd_idx_s1]) :
							os_used_q[rd_idx_s1]) && (now_q >= due_rd);
					end
				end
				S_MIN: begin
					if (rd_v_s1 && cand_q[rd_idx_s1] &&
							(!best_v_q || ident_rd < best_id_q)) begin
						best_v_q <= 1'b1;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						cand_q[best_slot_q] <= 1'b0;
						if (!kind_q) os_used_q[best_slot_q] <= 1'b0;
						n_q      <= n_q + 1'b1;
						last_q   <= emit_last;
						best_v_q <= 1'b0;
					end
				end
				S_FREE: p_used_q <= p_used_q & p_active_q;
				default: n_q <= n_q;
			endcase

			// Output register: a new result may replace one taken this cycle.
			if (emit_req && out_free) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q[SW-1:0];
		if (accept) begin
			kind_q     <= in_kind;
			delay_q    <= req.delay_value;
			id_q       <= req.timer_id;
			now_q      <= TW'(req.now_time);
			slot_q     <= free_slot;
			assigned_q <= '0;
			if (in_arm && in_neg) status_q <= ST_NEG;
			else if (in_arm && !free_found) status_q <= ST_FULL;
			else status_q <= ST_OK;
		end
		if (state_q == S_ARM) begin
			assigned_q <= kind_q ? next_p_id_q : next_os_id_q;
		end
		if (state_q == S_MIN && rd_v_s1 && cand_q[rd_idx_s1] &&
				(!best_v_q || ident_rd < best_id_q)) begin
			best_id_q   <= ident_rd;
			best_slot_q <= rd_idx_s1;
		end
		if (state_q == S_ADV_LD) begin
			per_q <= p_per_rd;
		end
		if (emit_req && out_free) begin
			out_status_q <= e_status;
			out_aid_q    <= e_aid;
			out_fid_q    <= e_fid;
			out_fv_q     <= e_fv;
			out_fk_q     <= e_fk;
			out_last_q   <= e_last;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.status      = out_status_q;
	assign rsp.assigned_id = out_aid_q;
	assign rsp.fired_id    = out_fid_q;
	assign rsp.fired_valid = out_fv_q;
	assign rsp.fired_kind  = out_fk_q;
	assign rsp.last        = out_last_q;

	// An armed slot was free when it was chosen.
	a_arm_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ARM |-> (kind_q ? !p_used_q[slot_q] : !os_used_q[slot_q]))
		else $error("arming an occupied slot");

	// An active periodic timer always occupies its slot.
	a_active_used: assert property (@(posedge clk) disable iff (!arst_n)
		(p_active_q & ~p_used_q) == '0)
		else $error("active periodic timer in a free slot");

	// The end of a periodic tick frees every inactive slot.
	a_free_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FREE |=> (p_used_q & ~p_active_q) == '0)
		else $error("inactive periodic slot left in use");

	// The remainder unit completes only while the controller waits for it.
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_ADV_DIV)
		else $error("remainder unit finished out of turn");

	// No tick reports more timers than allowed.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_RESULTS))
		else $error("too many fired timers");
endmodule
